// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// Holds the include guard and the clocked implication forms only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/i2sprs_pkg.sv
// Package for the I2S prescaler rate selector.
// Holds field widths, rate limits and status codes; no dependencies.
package i2sprs_pkg;

    localparam int MCLK_W = 29;
    localparam int RATE_W = 20;
    localparam int ACH_W  = 17;
    localparam int PRE_W  = 5;
    localparam int ST_W   = 2;

    localparam logic [MCLK_W-1:0] MCLK_RESET = MCLK_W'(12000000);
    localparam logic [ACH_W-1:0]  RATE_FLOOR = ACH_W'(4000);
    localparam logic [ACH_W-1:0]  RATE_CEIL  = ACH_W'(100000);

    typedef logic [ST_W-1:0] t_status;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_LOW   = 2'd1;
    localparam t_status ST_HIGH  = 2'd2;
    localparam t_status ST_RANGE = 2'd3;

endpackage

// File: rtl/core/i2s_prescaler_rate_select.sv
// I2S prescaler rate selector: pipelined divider chains for 256fs and 384fs.
// Depends on i2sprs_pkg.
//
// Usage:
//   Input channel: i_valid / o_stall with i_wanted_rate. A transaction
//   completes on a clock edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with o_status, o_prescale_value,
//   o_ratio_is_384 and o_achieved_rate; one result per request, in order.
//   Config channel: i_cfg_valid / o_cfg_ready with i_cfg_data, the master
//   clock in hertz. Write it only while no request is in flight.
//   Throughput: one request per cycle while the output is not stalled. The
//   pipeline holds the two restoring dividers in turn, one
//   quotient bit per stage: first the divider, then the achieved rate.
//   Reset clears all valid bits and loads the master clock with 12 MHz.
//   When the receiver stalls a waiting result, the whole pipeline holds and
//   o_stall rises; nothing is dropped or repeated.
//   Status: ok, rate too low (zero request or zero divider), rate too high
//   (divider above MAX_DIVIDER), achieved rate outside 4000..100000.
module i2s_prescaler_rate_select #(
    parameter int MAX_DIVIDER = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [i2sprs_pkg::RATE_W-1:0]    i_wanted_rate,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [i2sprs_pkg::ST_W-1:0]      o_status,
    output logic [i2sprs_pkg::PRE_W-1:0]     o_prescale_value,
    output logic                             o_ratio_is_384,
    output logic [i2sprs_pkg::ACH_W-1:0]     o_achieved_rate,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [i2sprs_pkg::MCLK_W-1:0]    i_cfg_data
);
    import i2sprs_pkg::*;

    localparam int QW  = $clog2(MAX_DIVIDER + 1);
    localparam int NW  = 30;
    localparam int DW1 = 29;
    localparam int CW1 = DW1 + QW + 1;
    localparam int DW2 = QW + 9;
    localparam int CW2 = DW2 + ACH_W + 1;
    localparam int RW  = ACH_W;
    localparam int XW  = (QW > PRE_W) ? QW : PRE_W;

    logic adv;
    logic [MCLK_W-1:0] r_mclk;

    // divider stage
    logic            r1_v     [0:QW];
    logic [RATE_W-1:0] r1_rate [0:QW];
    logic [NW-1:0]   r1_remA  [0:QW];
    logic [NW-1:0]   r1_remB  [0:QW];
    logic [DW1-1:0]  r1_denA  [0:QW];
    logic [DW1-1:0]  r1_denB  [0:QW];
    logic [QW-1:0]   r1_qA    [0:QW];
    logic [QW-1:0]   r1_qB    [0:QW];
    logic            r1_ovfA  [0:QW];
    logic            r1_ovfB  [0:QW];
    logic            n1_v     [0:QW];
    logic [RATE_W-1:0] n1_rate [0:QW];
    logic [NW-1:0]   n1_remA  [0:QW];
    logic [NW-1:0]   n1_remB  [0:QW];
    logic [DW1-1:0]  n1_denA  [0:QW];
    logic [DW1-1:0]  n1_denB  [0:QW];
    logic [QW-1:0]   n1_qA    [0:QW];
    logic [QW-1:0]   n1_qB    [0:QW];
    logic            n1_ovfA  [0:QW];
    logic            n1_ovfB  [0:QW];

    // achieved-rate stage
    logic            r2_v     [0:RW];
    logic [RATE_W-1:0] r2_rate [0:RW];
    t_status         r2_st    [0:RW];
    logic [QW-1:0]   r2_dA    [0:RW];
    logic [QW-1:0]   r2_dB    [0:RW];
    logic [NW-1:0]   r2_remA  [0:RW];
    logic [NW-1:0]   r2_remB  [0:RW];
    logic [DW2-1:0]  r2_denA  [0:RW];
    logic [DW2-1:0]  r2_denB  [0:RW];
    logic [RW-1:0]   r2_qA    [0:RW];
    logic [RW-1:0]   r2_qB    [0:RW];
    logic            r2_ovfA  [0:RW];
    logic            r2_ovfB  [0:RW];
    logic            n2_v     [0:RW];
    logic [RATE_W-1:0] n2_rate [0:RW];
    t_status         n2_st    [0:RW];
    logic [QW-1:0]   n2_dA    [0:RW];
    logic [QW-1:0]   n2_dB    [0:RW];
    logic [NW-1:0]   n2_remA  [0:RW];
    logic [NW-1:0]   n2_remB  [0:RW];
    logic [DW2-1:0]  n2_denA  [0:RW];
    logic [DW2-1:0]  n2_denB  [0:RW];
    logic [RW-1:0]   n2_qA    [0:RW];
    logic [RW-1:0]   n2_qB    [0:RW];
    logic            n2_ovfA  [0:RW];
    logic            n2_ovfB  [0:RW];

    logic              r_out_v;
    t_status           r_out_st;
    logic [PRE_W-1:0]  r_out_pre;
    logic              r_out_384;
    logic [ACH_W-1:0]  r_out_ach;
    t_status           n_out_st;
    logic [PRE_W-1:0]  n_out_pre;
    logic              n_out_384;
    logic [ACH_W-1:0]  n_out_ach;

    logic [RATE_W-1:0] fin_rate;
    logic [ACH_W-1:0]  fin_rA;
    logic [ACH_W-1:0]  fin_rB;
    logic [RATE_W:0]   fin_eA;
    logic [RATE_W:0]   fin_eB;
    logic              fin_bad;
    logic [XW-1:0]     fin_dm1A;
    logic [XW-1:0]     fin_dm1B;
    logic              ent_low;
    logic              ent_high;

    assign adv         = !(r_out_v && i_stall);
    assign o_stall     = !adv;
    assign o_cfg_ready = 1'b1;

    // divider chain: round(mclk / (fs * rate)), flagging overflow above QW bits
    always_comb begin
        n1_v[0]    = i_valid;
        n1_rate[0] = i_wanted_rate;
        n1_remA[0] = NW'(r_mclk) + (NW'(i_wanted_rate) << 7);
        n1_remB[0] = NW'(r_mclk) + (NW'(i_wanted_rate) << 7) + (NW'(i_wanted_rate) << 6);
        n1_denA[0] = DW1'(i_wanted_rate) << 8;
        n1_denB[0] = (DW1'(i_wanted_rate) << 8) + (DW1'(i_wanted_rate) << 7);
        n1_qA[0]   = '0;
        n1_qB[0]   = '0;
        n1_ovfA[0] = CW1'(n1_remA[0]) >= (CW1'(n1_denA[0]) << QW);
        n1_ovfB[0] = CW1'(n1_remB[0]) >= (CW1'(n1_denB[0]) << QW);
        for (int j = 1; j <= QW; j++) begin
            n1_v[j]    = r1_v[j-1];
            n1_rate[j] = r1_rate[j-1];
            n1_denA[j] = r1_denA[j-1];
            n1_denB[j] = r1_denB[j-1];
            n1_ovfA[j] = r1_ovfA[j-1];
            n1_ovfB[j] = r1_ovfB[j-1];
            n1_remA[j] = r1_remA[j-1];
            n1_remB[j] = r1_remB[j-1];
            n1_qA[j]   = r1_qA[j-1];
            n1_qB[j]   = r1_qB[j-1];
            if (CW1'(r1_remA[j-1]) >= (CW1'(r1_denA[j-1]) << (QW - j))) begin
                n1_remA[j] = NW'(CW1'(r1_remA[j-1]) - (CW1'(r1_denA[j-1]) << (QW - j)));
                n1_qA[j][QW-j] = 1'b1;
            end
            if (CW1'(r1_remB[j-1]) >= (CW1'(r1_denB[j-1]) << (QW - j))) begin
                n1_remB[j] = NW'(CW1'(r1_remB[j-1]) - (CW1'(r1_denB[j-1]) << (QW - j)));
                n1_qB[j][QW-j] = 1'b1;
            end
        end
    end

    // achieved-rate chain: round(mclk / (fs * divider)), flagging overflow above RW bits
    always_comb begin
        ent_low  = (r1_rate[QW] == '0) || (r1_qA[QW] == '0) || (r1_qB[QW] == '0);
        ent_high = r1_ovfA[QW] || r1_ovfB[QW] ||
                   (r1_qA[QW] > QW'(MAX_DIVIDER)) || (r1_qB[QW] > QW'(MAX_DIVIDER));
        n2_v[0]    = r1_v[QW];
        n2_rate[0] = r1_rate[QW];
        n2_st[0]   = ent_low ? ST_LOW : (ent_high ? ST_HIGH : ST_OK);
        n2_dA[0]   = r1_qA[QW];
        n2_dB[0]   = r1_qB[QW];
        n2_remA[0] = NW'(r_mclk) + (NW'(r1_qA[QW]) << 7);
        n2_remB[0] = NW'(r_mclk) + (NW'(r1_qB[QW]) << 7) + (NW'(r1_qB[QW]) << 6);
        n2_denA[0] = DW2'(r1_qA[QW]) << 8;
        n2_denB[0] = (DW2'(r1_qB[QW]) << 8) + (DW2'(r1_qB[QW]) << 7);
        n2_qA[0]   = '0;
        n2_qB[0]   = '0;
        n2_ovfA[0] = CW2'(n2_remA[0]) >= (CW2'(n2_denA[0]) << RW);
        n2_ovfB[0] = CW2'(n2_remB[0]) >= (CW2'(n2_denB[0]) << RW);
        for (int j = 1; j <= RW; j++) begin
            n2_v[j]    = r2_v[j-1];
            n2_rate[j] = r2_rate[j-1];
            n2_st[j]   = r2_st[j-1];
            n2_dA[j]   = r2_dA[j-1];
            n2_dB[j]   = r2_dB[j-1];
            n2_denA[j] = r2_denA[j-1];
            n2_denB[j] = r2_denB[j-1];
            n2_ovfA[j] = r2_ovfA[j-1];
            n2_ovfB[j] = r2_ovfB[j-1];
            n2_remA[j] = r2_remA[j-1];
            n2_remB[j] = r2_remB[j-1];
            n2_qA[j]   = r2_qA[j-1];
            n2_qB[j]   = r2_qB[j-1];
            if (CW2'(r2_remA[j-1]) >= (CW2'(r2_denA[j-1]) << (RW - j))) begin
                n2_remA[j] = NW'(CW2'(r2_remA[j-1]) - (CW2'(r2_denA[j-1]) << (RW - j)));
                n2_qA[j][RW-j] = 1'b1;
            end
            if (CW2'(r2_remB[j-1]) >= (CW2'(r2_denB[j-1]) << (RW - j))) begin
                n2_remB[j] = NW'(CW2'(r2_remB[j-1]) - (CW2'(r2_denB[j-1]) << (RW - j)));
                n2_qB[j][RW-j] = 1'b1;
            end
        end
    end

    // range check and pick the closer ratio, ties to 256fs
    always_comb begin
        fin_rate = r2_rate[RW];
        fin_rA   = r2_qA[RW];
        fin_rB   = r2_qB[RW];
        fin_bad  = r2_ovfA[RW] || r2_ovfB[RW] ||
                   (fin_rA < RATE_FLOOR) || (fin_rA > RATE_CEIL) ||
                   (fin_rB < RATE_FLOOR) || (fin_rB > RATE_CEIL);
        fin_eA   = ((RATE_W+1)'(fin_rate) <= (RATE_W+1)'(fin_rA)) ?
                   (RATE_W+1)'(fin_rA) - (RATE_W+1)'(fin_rate) :
                   (RATE_W+1)'(fin_rate) - (RATE_W+1)'(fin_rA);
        fin_eB   = ((RATE_W+1)'(fin_rate) <= (RATE_W+1)'(fin_rB)) ?
                   (RATE_W+1)'(fin_rB) - (RATE_W+1)'(fin_rate) :
                   (RATE_W+1)'(fin_rate) - (RATE_W+1)'(fin_rB);
        fin_dm1A = XW'(r2_dA[RW]) - XW'(1);
        fin_dm1B = XW'(r2_dB[RW]) - XW'(1);
        n_out_st  = r2_st[RW];
        n_out_pre = '0;
        n_out_384 = 1'b0;
        n_out_ach = '0;
        if (r2_st[RW] == ST_OK) begin
            if (fin_bad) begin
                n_out_st = ST_RANGE;
            end else if (fin_eA <= fin_eB) begin
                n_out_pre = fin_dm1A[PRE_W-1:0];
                n_out_ach = fin_rA;
            end else begin
                n_out_pre = fin_dm1B[PRE_W-1:0];
                n_out_384 = 1'b1;
                n_out_ach = fin_rB;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mclk  <= MCLK_RESET;
            r_out_v <= 1'b0;
            for (int j = 0; j <= QW; j++) begin
                r1_v[j] <= 1'b0;
            end
            for (int j = 0; j <= RW; j++) begin
                r2_v[j] <= 1'b0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_mclk <= i_cfg_data;
            end
            if (adv) begin
                r_out_v <= r2_v[RW];
                for (int j = 0; j <= QW; j++) begin
                    r1_v[j] <= n1_v[j];
                end
                for (int j = 0; j <= RW; j++) begin
                    r2_v[j] <= n2_v[j];
                end
            end
        end
    end

    // payload registers, held while the output is stalled
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j <= QW; j++) begin
                r1_rate[j] <= n1_rate[j];
                r1_remA[j] <= n1_remA[j];
                r1_remB[j] <= n1_remB[j];
                r1_denA[j] <= n1_denA[j];
                r1_denB[j] <= n1_denB[j];
                r1_qA[j]   <= n1_qA[j];
                r1_qB[j]   <= n1_qB[j];
                r1_ovfA[j] <= n1_ovfA[j];
                r1_ovfB[j] <= n1_ovfB[j];
            end
            for (int j = 0; j <= RW; j++) begin
                r2_rate[j] <= n2_rate[j];
                r2_st[j]   <= n2_st[j];
                r2_dA[j]   <= n2_dA[j];
                r2_dB[j]   <= n2_dB[j];
                r2_remA[j] <= n2_remA[j];
                r2_remB[j] <= n2_remB[j];
                r2_denA[j] <= n2_denA[j];
                r2_denB[j] <= n2_denB[j];
                r2_qA[j]   <= n2_qA[j];
                r2_qB[j]   <= n2_qB[j];
                r2_ovfA[j] <= n2_ovfA[j];
                r2_ovfB[j] <= n2_ovfB[j];
            end
            r_out_st  <= n_out_st;
            r_out_pre <= n_out_pre;
            r_out_384 <= n_out_384;
            r_out_ach <= n_out_ach;
        end
    end

    assign o_valid          = r_out_v;
    assign o_status         = r_out_st;
    assign o_prescale_value = r_out_pre;
    assign o_ratio_is_384   = r_out_384;
    assign o_achieved_rate  = r_out_ach;

endmodule

// File: rtl/core/i2sprs_checker.sv
// Port-level checker for the I2S prescaler rate selector, bound to the top.
// Depends on i2sprs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2sprs_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_stall,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic [i2sprs_pkg::ST_W-1:0]      o_status,
    input logic [i2sprs_pkg::PRE_W-1:0]     o_prescale_value,
    input logic                             o_ratio_is_384,
    input logic [i2sprs_pkg::ACH_W-1:0]     o_achieved_rate
);
    import i2sprs_pkg::*;

    `AST_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_achieved_rate) && $stable(o_status))
    `AST_SAME(a_err_zero, i_clk, i_rst_n, o_valid && (o_status != ST_OK), (o_prescale_value == '0) && !o_ratio_is_384 && (o_achieved_rate == '0))
    `AST_SAME(a_ok_range, i_clk, i_rst_n, o_valid && (o_status == ST_OK), (o_achieved_rate >= RATE_FLOOR) && (o_achieved_rate <= RATE_CEIL))
    `AST_SAME(a_stall_src, i_clk, i_rst_n, o_stall, o_valid && i_stall)

endmodule

bind i2s_prescaler_rate_select i2sprs_checker u_i2sprs_checker (.*);
